// File: rtl/lwue_pkg.sv
// lwue_pkg: shared types and constants of the lcd window update engine
// no dependencies; used by lwue_ctrl, lwue_dp and the top level
package lwue_pkg;

  // output word selector codes
  localparam logic [2:0] SEL_CMD   = 3'd0;
  localparam logic [2:0] SEL_OPEN  = 3'd1;
  localparam logic [2:0] SEL_CLOSE = 3'd2;

  // target ports
  localparam logic [1:0] PORT_LCD   = 2'd0;
  localparam logic [1:0] PORT_BCTRL = 2'd1;
  localparam logic [1:0] PORT_BLEN  = 2'd2;
  localparam logic [1:0] PORT_FIFO  = 2'd3;

  // port words
  localparam logic [31:0] SEND_LO    = 32'h8000_0000;
  localparam logic [31:0] SEND_HI    = 32'h8100_0000;
  localparam logic [31:0] BLEN_BASE  = 32'hC001_0000;
  localparam logic [31:0] BURST_ARM  = 32'h1000_0080;
  localparam logic [31:0] BURST_GO   = 32'h3400_0000;

  // controller command and register indexes
  localparam logic [7:0] REG_HWIN   = 8'h44;
  localparam logic [7:0] REG_VWIN   = 8'h45;
  localparam logic [7:0] REG_CURSOR = 8'h21;
  localparam logic [7:0] REG_GRAM   = 8'h22;
  localparam logic [7:0] CMD_X0     = 8'h12;
  localparam logic [7:0] CMD_Y0     = 8'h13;
  localparam logic [7:0] CMD_X1     = 8'h15;
  localparam logic [7:0] CMD_Y1     = 8'h16;

  // configuration register indexes
  localparam logic [1:0] CFG_ROTATED = 2'd0;
  localparam logic [1:0] CFG_KIND    = 2'd1;
  localparam logic [1:0] CFG_PWIDTH  = 2'd2;

  // last step of the window command sequence per controller kind
  localparam logic [3:0] LAST_STEP_K0 = 4'd7;
  localparam logic [3:0] LAST_STEP_K1 = 4'd13;

  typedef struct packed {
    logic       load_rect;
    logic       pair;
    logic       sort;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic       emit_last;
    logic [2:0] sel;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic can_load;
    logic active;
    logic kind;
    logic burst_end;
    logic over;
    logic div_done;
    logic rows_zero;
  } sts_t;

  // high data byte as the model forms it: (hi << 8 | lo) >> 8, lo sign-extended
  function automatic logic [7:0] hi_byte(logic signed [10:0] hi, logic signed [10:0] lo);
    hi_byte = hi[7:0] | {{5{lo[10]}}, lo[10:8]};
  endfunction

endpackage

// File: rtl/lwue_ctrl.sv
// lwue_ctrl: sequencer of the lcd window update engine
// depends on lwue_pkg; drives lwue_dp through cmd_t and reads sts_t
module lwue_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tuser,
  output logic            in_tready,
  input  lwue_pkg::sts_t  sts,
  output lwue_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SORT  = 4'd1;
  localparam logic [3:0] S_CMD   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_OPEN  = 4'd7;
  localparam logic [3:0] S_CLOSE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [3:0] last_step;

  assign last_step = sts.kind ? lwue_pkg::LAST_STEP_K1 : lwue_pkg::LAST_STEP_K0;
  assign in_tready = (state_r == S_IDLE) && sts.can_load;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (!in_tuser) begin
            cmd.load_rect = 1'b1;
            state_nxt     = S_SORT;
          end else begin
            cmd.pair = 1'b1;
            if (sts.active && sts.burst_end) state_nxt = S_CLOSE;
          end
        end
      end
      S_SORT: begin
        cmd.sort  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_CMD;
      end
      S_CMD: begin
        if (sts.can_load) begin
          cmd.emit      = 1'b1;
          cmd.sel       = lwue_pkg::SEL_CMD;
          cmd.emit_last = (step_r == last_step) && !sts.active;
          if (step_r == last_step) begin
            state_nxt = sts.active ? S_MUL : S_IDLE;
          end else begin
            step_nxt = step_r + 4'd1;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        step_nxt  = '0;
        state_nxt = sts.over ? S_DIVI : S_OPEN;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_OPEN: begin
        if (sts.can_load) begin
          cmd.emit      = 1'b1;
          cmd.sel       = lwue_pkg::SEL_OPEN;
          cmd.emit_last = (step_r == 4'd2);
          if (step_r == 4'd2) state_nxt = S_IDLE;
          else step_nxt = step_r + 4'd1;
        end
      end
      S_CLOSE: begin
        if (sts.can_load) begin
          cmd.emit      = 1'b1;
          cmd.sel       = lwue_pkg::SEL_CLOSE;
          cmd.emit_last = sts.rows_zero;
          state_nxt     = sts.rows_zero ? S_IDLE : S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: rtl/lwue_dp.sv
// lwue_dp: window arithmetic, burst bookkeeping, divider and output register
// depends on lwue_pkg; commanded by lwue_ctrl
module lwue_dp #(
  parameter int CHUNK_BYTES = 64000
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic [63:0]     in_tdata,
  input  lwue_pkg::cmd_t  cmd,
  output lwue_pkg::sts_t  sts,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  localparam int QV = CHUNK_BYTES / 2;
  localparam int QW = $clog2(QV + 1);
  localparam int CW = $clog2(QW);
  localparam logic [18:0] CHUNK_L = 19'(CHUNK_BYTES);

  // configuration
  logic       rot_r, kind_r;
  logic [7:0] panel_w_r;

  // window edges and data words
  logic signed [10:0] r1_r, r2_r, r3_r, r4_r;
  logic [15:0] d44_r, d45_r, d21_r;

  // burst state
  logic [8:0] pw_r, rows_left_r, burst_rows_r, row_r, h_r;
  logic [7:0] pair_r;
  logic       active_r;
  logic [18:0] bytes_r;
  logic [17:0] area;

  // divider
  logic [QW-1:0] quot_r, quot_nxt;
  logic [9:0]    rem_r, rem_nxt, rem_sh;
  logic [CW-1:0] cnt_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_port_r, port_sel;
  logic [31:0] out_word_r, word_sel;
  logic        out_last_r;

  // input fields
  logic [7:0]  f_x, f_y, f_w, f_h;
  logic [15:0] f_p0, f_p1;
  assign f_x  = in_tdata[7:0];
  assign f_y  = in_tdata[15:8];
  assign f_w  = in_tdata[23:16];
  assign f_h  = in_tdata[31:24];
  assign f_p0 = in_tdata[47:32];
  assign f_p1 = in_tdata[63:48];

  // rectangle edges
  logic [8:0] w9;
  logic signed [10:0] sx, sy, sw, sh, spw, e2;
  assign w9  = {1'b0, f_w} + {8'd0, f_w[0]};
  assign sx  = $signed({3'b0, f_x});
  assign sy  = $signed({3'b0, f_y});
  assign sw  = $signed({2'b0, w9});
  assign sh  = $signed({3'b0, f_h});
  assign spw = $signed({3'b0, panel_w_r});
  assign e2  = spw - 11'sd1 - sx;

  // sorted edges
  logic signed [10:0] s1, s2, s3, s4, c2;
  assign s1 = (r3_r < r1_r) ? r3_r : r1_r;
  assign s3 = (r3_r < r1_r) ? r1_r : r3_r;
  assign s2 = (r4_r < r2_r) ? r4_r : r2_r;
  assign s4 = (r4_r < r2_r) ? r2_r : r4_r;
  assign c2 = rot_r ? s4 : s2;

  // pair bookkeeping
  logic [8:0] pair_inc, row_inc, rows_after;
  logic       row_end, burst_end;
  assign pair_inc   = {1'b0, pair_r} + 9'd1;
  assign row_inc    = row_r + 9'd1;
  assign row_end    = pair_inc >= {1'b0, pw_r[8:1]};
  assign burst_end  = row_end && (row_inc >= burst_rows_r);
  assign rows_after = rows_left_r - burst_rows_r;

  // pixels in the burst, full width product
  assign area = {9'd0, pw_r} * {9'd0, h_r};

  logic can_load;
  assign can_load = !out_valid_r || out_tready;

  assign sts.can_load  = can_load;
  assign sts.active    = active_r;
  assign sts.kind      = kind_r;
  assign sts.burst_end = burst_end;
  assign sts.over      = bytes_r > CHUNK_L;
  assign sts.div_done  = cnt_r == CW'(QW - 1);
  assign sts.rows_zero = rows_left_r == 9'd0;

  // restoring divide of the half chunk by the padded width
  assign rem_sh   = {rem_r[8:0], quot_r[QW-1]};
  always_comb begin
    if (rem_sh >= {1'b0, pw_r}) begin
      rem_nxt  = rem_sh - {1'b0, pw_r};
      quot_nxt = {quot_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      quot_nxt = {quot_r[QW-2:0], 1'b0};
    end
  end

  // command word table
  logic [31:0] cmd_word;
  always_comb begin
    cmd_word = lwue_pkg::SEND_LO;
    if (!kind_r) begin
      case (cmd.step)
        4'd0:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::CMD_X0};
        4'd1:    cmd_word = lwue_pkg::SEND_LO | {24'd0, r1_r[7:0]};
        4'd2:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::CMD_Y0};
        4'd3:    cmd_word = lwue_pkg::SEND_LO | {24'd0, r2_r[7:0]};
        4'd4:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::CMD_X1};
        4'd5:    cmd_word = lwue_pkg::SEND_LO | {24'd0, r3_r[7:0]};
        4'd6:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::CMD_Y1};
        4'd7:    cmd_word = lwue_pkg::SEND_LO | {24'd0, r4_r[7:0]};
        default: cmd_word = lwue_pkg::SEND_LO;
      endcase
    end else begin
      case (cmd.step)
        4'd0:    cmd_word = lwue_pkg::SEND_LO;
        4'd1:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::REG_HWIN};
        4'd2:    cmd_word = lwue_pkg::SEND_HI | {24'd0, d44_r[15:8]};
        4'd3:    cmd_word = lwue_pkg::SEND_HI | {24'd0, d44_r[7:0]};
        4'd4:    cmd_word = lwue_pkg::SEND_LO;
        4'd5:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::REG_VWIN};
        4'd6:    cmd_word = lwue_pkg::SEND_HI | {24'd0, d45_r[15:8]};
        4'd7:    cmd_word = lwue_pkg::SEND_HI | {24'd0, d45_r[7:0]};
        4'd8:    cmd_word = lwue_pkg::SEND_LO;
        4'd9:    cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::REG_CURSOR};
        4'd10:   cmd_word = lwue_pkg::SEND_HI | {24'd0, d21_r[15:8]};
        4'd11:   cmd_word = lwue_pkg::SEND_HI | {24'd0, d21_r[7:0]};
        4'd12:   cmd_word = lwue_pkg::SEND_LO;
        4'd13:   cmd_word = lwue_pkg::SEND_LO | {24'd0, lwue_pkg::REG_GRAM};
        default: cmd_word = lwue_pkg::SEND_LO;
      endcase
    end
  end

  always_comb begin
    port_sel = lwue_pkg::PORT_LCD;
    word_sel = cmd_word;
    case (cmd.sel)
      lwue_pkg::SEL_CMD: begin
        port_sel = lwue_pkg::PORT_LCD;
        word_sel = cmd_word;
      end
      lwue_pkg::SEL_OPEN: begin
        case (cmd.step)
          4'd0: begin
            port_sel = lwue_pkg::PORT_BCTRL;
            word_sel = lwue_pkg::BURST_ARM;
          end
          4'd1: begin
            port_sel = lwue_pkg::PORT_BLEN;
            word_sel = ({13'd0, bytes_r} - 32'd1) | lwue_pkg::BLEN_BASE;
          end
          default: begin
            port_sel = lwue_pkg::PORT_BCTRL;
            word_sel = lwue_pkg::BURST_GO;
          end
        endcase
      end
      lwue_pkg::SEL_CLOSE: begin
        port_sel = lwue_pkg::PORT_BLEN;
        word_sel = '0;
      end
      default: begin
        port_sel = lwue_pkg::PORT_LCD;
        word_sel = cmd_word;
      end
    endcase
  end

  logic pix_load;
  assign pix_load = cmd.pair && active_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r        <= 1'b1;
      kind_r       <= 1'b0;
      panel_w_r    <= 8'd220;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      pw_r         <= '0;
      rows_left_r  <= '0;
      burst_rows_r <= '0;
      row_r        <= '0;
      pair_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lwue_pkg::CFG_ROTATED: rot_r     <= cfg_data[0];
          lwue_pkg::CFG_KIND:    kind_r    <= cfg_data[0];
          lwue_pkg::CFG_PWIDTH:  panel_w_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.emit || pix_load) out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
      if (cmd.load_rect) begin
        pw_r         <= w9;
        rows_left_r  <= {1'b0, f_h};
        burst_rows_r <= '0;
        row_r        <= '0;
        pair_r       <= '0;
        active_r     <= (w9 != 9'd0) && (f_h != 8'd0);
      end
      if (cmd.emit && cmd.sel == lwue_pkg::SEL_OPEN && cmd.step == 4'd0) begin
        burst_rows_r <= h_r;
        row_r        <= '0;
        pair_r       <= '0;
      end
      if (pix_load) begin
        if (!row_end) begin
          pair_r <= pair_inc[7:0];
        end else begin
          pair_r <= '0;
          if (burst_end) begin
            row_r       <= '0;
            rows_left_r <= rows_after;
            active_r    <= rows_after != 9'd0;
          end else begin
            row_r <= row_inc;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_rect) begin
      h_r <= {1'b0, f_h};
      if (rot_r) begin
        r1_r <= sy;
        r2_r <= e2;
        r3_r <= sy + sh - 11'sd1;
        r4_r <= e2 - sw + 11'sd1;
      end else begin
        r1_r <= sx;
        r2_r <= sy;
        r3_r <= sx + sw - 11'sd1;
        r4_r <= sy + sh - 11'sd1;
      end
    end
    if (cmd.sort) begin
      d44_r <= {lwue_pkg::hi_byte(s3, s1), s1[7:0]};
      d45_r <= {lwue_pkg::hi_byte(s4, s2), s2[7:0]};
      d21_r <= {lwue_pkg::hi_byte(c2, s1), s1[7:0]};
    end
    if (pix_load && burst_end) h_r <= rows_after;
    if (cmd.mul) bytes_r <= {area, 1'b0};
    if (cmd.div_init) begin
      quot_r <= QW'(QV);
      rem_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r + CW'(1);
      if (sts.div_done) h_r <= quot_nxt[8:0];
    end
    if (pix_load) begin
      out_port_r <= lwue_pkg::PORT_FIFO;
      out_word_r <= {f_p1[7:0], f_p1[15:8], f_p0[7:0], f_p0[15:8]};
      out_last_r <= !burst_end;
    end else if (cmd.emit) begin
      out_port_r <= port_sel;
      out_word_r <= word_sel;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_port_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/lcd_window_update_engine_unit.sv
// lcd_window_update_engine_unit: top level of the lcd window update engine
// depends on lwue_pkg, lwue_ctrl and lwue_dp
//
// channel  | direction | transfer carries
// in_*     | slave     | req_type in tuser, rectangle and pixel pair in tdata
// out_*    | master    | target port in tuser, write word in tdata, last write in tlast
// cfg_*    | slave     | register index and write data, always ready
//
// a pixel pair in an active burst is one fifo write; a burst end adds the close write and,
// while rows remain, the three writes of the next burst setup
// a rectangle takes the sort state, 8 or 14 command writes and, if not empty, the burst setup;
// a clamped burst runs the restoring divider, one quotient bit a cycle
// reset is synchronous active low and clears all control state
// a stalled output holds the result register and blocks further transfers in
module lcd_window_update_engine_unit #(
  parameter int CHUNK_BYTES = 64000
) (
  input  logic        clk,
  input  logic        rst_n,
  // rect_x, rect_y, rect_width, rect_height, pixel_first, pixel_second
  input  logic [63:0] in_tdata,
  // req_type
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // write_word
  output logic [31:0] out_tdata,
  // target_port
  output logic [1:0]  out_tuser,
  // last_write
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  lwue_pkg::cmd_t cmd;
  lwue_pkg::sts_t sts;

  // configuration is taken at any cycle
  assign cfg_ready = 1'b1;

  lwue_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lwue_dp #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
